/* src/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants of the range partition assigner.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int unsigned TopicW  = 10;
  localparam int unsigned CountW  = 16;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned MemberW = 4;
  localparam int unsigned NumW    = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WALK
  } rpa_state_e;

  // number of set bits of the mask, summed per nibble first
  function automatic logic [NumW-1:0] popcount16(input logic [MaskW-1:0] m);
    logic [2:0]      nib [4];
    logic [NumW-1:0] sum;
    sum = '0;
    for (int j = 0; j < 4; j++) begin
      nib[j] = 3'(m[4*j]) + 3'(m[4*j+1]) + 3'(m[4*j+2]) + 3'(m[4*j+3]);
    end
    for (int j = 0; j < 4; j++) begin
      sum = sum + NumW'(nib[j]);
    end
    return sum;
  endfunction

endpackage

/* src/range_partition_assigner_core.sv */
// ----------------------------------------------------------------------------
// range_partition_assigner_core
// Range assignment of one topic's partitions over its interested members.
// ----------------------------------------------------------------------------
// Each request names a topic, its partition count and the mask of interested
// members. The partitions are split by a shift-subtract divider, one quotient
// bit per cycle, then the mask is walked one bit per cycle unless a result
// waits on a stalled output, and each member with a non-empty share gets one
// result holding its first partition and run length; the last result of a
// topic carries last_of_topic. A new request is not accepted until the walk
// of the last one is done; requests with an empty mask or zero partitions
// give no result and leave the core idle. in_stall_o is high while a request
// is being worked on. Mask bits at or above MEMBERS are ignored.
module range_partition_assigner_core
  import rpa_pkg::*;
#(
  parameter int unsigned MEMBERS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TopicW-1:0]    topic_index_i,
  input  logic [CountW-1:0]    partition_count_i,
  input  logic [MaskW-1:0]     interested_mask_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TopicW-1:0]    topic_echo_o,
  output logic [MemberW-1:0]   member_index_o,
  output logic [CountW-1:0]    first_partition_o,
  output logic [CountW-1:0]    run_length_o,
  output logic                 last_of_topic_o
);

  localparam logic [MaskW-1:0] GroupMask =
    (MEMBERS >= MaskW) ? {MaskW{1'b1}} : MaskW'((64'd1 << MEMBERS) - 64'd1);

  rpa_state_e state_q, state_d;

  logic [TopicW-1:0]  topic_q;
  logic [MaskW-1:0]   mask_q, mask_d;
  logic [NumW-1:0]    n_q;
  logic [CountW-1:0]  acc_q, acc_d;
  logic [MemberW-1:0] rem_q, rem_d;
  logic [MemberW-1:0] step_q;
  logic [MemberW-1:0] pos_q;
  logic [NumW-1:0]    k_q;
  logic [CountW-1:0]  next_q;

  logic               out_valid_q;
  logic [TopicW-1:0]  out_topic_q;
  logic [MemberW-1:0] out_member_q;
  logic [CountW-1:0]  out_first_q;
  logic [CountW-1:0]  out_run_q;
  logic               out_last_q;

  logic [MaskW-1:0]   in_mask;
  logic [NumW-1:0]    in_num;
  logic               in_accept;
  logic               in_empty;
  logic [NumW-1:0]    trial;
  logic               trial_ge;
  logic               cur_bit;
  logic [MaskW-1:0]   rest_mask;
  logic               k_lt_extra;
  logic [CountW-1:0]  take;
  logic               take_zero;
  logic               is_last;
  logic               slot_free;
  logic               load_out;
  logic               walk_step;
  logic               walk_done;

  // datapath and output control
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_mask    = interested_mask_i & GroupMask;
    in_num     = popcount16(in_mask);
    in_accept  = in_valid_i && !in_stall_o;
    in_empty   = (in_num == '0) || (partition_count_i == '0);

    trial    = {rem_q, acc_q[CountW-1]};
    trial_ge = (trial >= n_q);
    acc_d    = {acc_q[CountW-2:0], trial_ge};
    rem_d    = trial_ge ? MemberW'(trial - n_q) : MemberW'(trial);

    cur_bit    = mask_q[pos_q];
    rest_mask  = mask_q & ~(MaskW'(1) << pos_q);
    k_lt_extra = (k_q < NumW'(rem_q));
    take       = acc_q + CountW'(k_lt_extra);
    take_zero  = (take == '0);
    is_last    = (rest_mask == '0) ||
                 ((acc_q == '0) && ((k_q + NumW'(1)) == NumW'(rem_q)));
    slot_free  = !out_valid_q || !out_stall_i;

    load_out  = (state_q == ST_WALK) && cur_bit && !take_zero && slot_free;
    walk_step = (state_q == ST_WALK) && (!cur_bit || take_zero || slot_free);
    walk_done = walk_step && cur_bit && (take_zero || is_last);
    mask_d    = rest_mask;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && !in_empty) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step_q == '1) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      topic_q <= topic_index_i;
      mask_q  <= in_mask;
      n_q     <= in_num;
      acc_q   <= partition_count_i;
      rem_q   <= '0;
      step_q  <= '0;
      pos_q   <= '0;
      k_q     <= '0;
      next_q  <= '0;
    end else if (state_q == ST_DIVIDE) begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      step_q <= step_q + MemberW'(1);
    end else if (walk_step) begin
      pos_q <= pos_q + MemberW'(1);
      if (cur_bit) begin
        mask_q <= mask_d;
        k_q    <= k_q + NumW'(1);
        next_q <= next_q + take;
      end
    end
    if (load_out) begin
      out_topic_q  <= topic_q;
      out_member_q <= pos_q;
      out_first_q  <= next_q;
      out_run_q    <= take;
      out_last_q   <= is_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign topic_echo_o      = out_topic_q;
  assign member_index_o    = out_member_q;
  assign first_partition_o = out_first_q;
  assign run_length_o      = out_run_q;
  assign last_of_topic_o   = out_last_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) && (step_q == '1) |=> (NumW'(rem_q) < n_q))
    else $error("remainder not below member count after divide");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_length_o != '0))
    else $error("empty run presented");

  a_k_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (k_q < n_q))
    else $error("walk passed the last interested member");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && is_last |=> (state_q == ST_IDLE))
    else $error("walk continues after last run");

endmodule
